### rtl/lcg_pkg.sv
// Package for the LCG random generator: sequencer states, register indexes,
// reset values and divider step counts. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcg_pkg;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_FRAC = 5'b00100,
    ST_MOD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MULT    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCR    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 8'd3;

  localparam logic [31:0] RST_MULT = 32'd1664525;
  localparam logic [31:0] RST_INCR = 32'd1013904223;
  localparam logic [31:0] RST_MOD  = 32'd2147483647;
  localparam logic [30:0] RST_SEED = 31'd8992822;

  localparam logic [31:0] MOD_CAP  = 32'h8000_0000;
  localparam logic [31:0] FRAC_SAT = 32'hFFFF_FFFF;

  localparam int unsigned CNT_W      = 6;
  localparam int unsigned FRAC_STEPS = 32;
  localparam int unsigned MOD_STEPS  = 64;

endpackage

`default_nettype wire

### rtl/lcg_random_generator_unit.sv
// LCG random generator top level: config registers, multiplier, shared
// restoring-divider step unit and its sequencer. Depends on lcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 mult,
//   1 incr, 2 modulus, 3 seed_start (also loads the generator value). Other
//   indexes are ignored. cfg_ready is always high; write only while idle.
//   s_axis: one transfer per draw request, tdata[0] = draw. A transfer with
//   draw low produces no result.
//   m_axis: one transfer per draw: raw_value and its Q0.32 fraction of the
//   modulus.
// Sequence:
//   A draw passes through the multiplier, then 32 divider steps for the
//   fraction and 64 divider steps for the modulo reduction, all on one
//   shared compare/subtract unit, then loads the output register. A new
//   draw is not accepted until the current one has left the output step:
//   s_axis_tready is low while a draw is in progress.
// Stall: a pending result sits in the output register while the next draw is
//   accepted; a finished draw waits in its last step until that register is
//   free.
// Reset: registers return to their default values, value = seed default.
module lcg_random_generator_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [0] draw, [7:1] zero
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata    // [30:0] raw_value, [62:31] fraction, [63] zero
);

  lcg_pkg::state_t state;

  logic [31:0] mult;
  logic [31:0] incr;
  logic [31:0] modulus;
  logic [30:0] current_value;

  logic [31:0] meff;
  logic [62:0] prod;
  logic [63:0] dvd;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] frac;
  logic        sat;
  logic [lcg_pkg::CNT_W-1:0] cnt;

  logic [30:0] out_raw;
  logic [31:0] out_frac;
  logic        out_valid;

  // shared divider step
  logic [32:0] step_t;
  logic        step_q;
  logic [31:0] step_rem;

  logic in_xfer;
  logic out_load;

  always_comb begin
    if (modulus == 32'd0) begin
      meff = 32'd1;
    end else if (modulus > lcg_pkg::MOD_CAP) begin
      meff = lcg_pkg::MOD_CAP;
    end else begin
      meff = modulus;
    end
  end

  always_comb begin
    step_t = {rem, dvd[63]};
    step_q = (step_t >= {1'b0, meff});
    if (step_q) begin
      step_rem = 32'(step_t - {1'b0, meff});
    end else begin
      step_rem = step_t[31:0];
    end
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == lcg_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == lcg_pkg::ST_OUT) && (!out_valid || m_axis_tready);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_frac, out_raw};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lcg_pkg::ST_IDLE;
      mult          <= lcg_pkg::RST_MULT;
      incr          <= lcg_pkg::RST_INCR;
      modulus       <= lcg_pkg::RST_MOD;
      current_value <= lcg_pkg::RST_SEED;
      out_valid     <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lcg_pkg::CFG_MULT:    mult          <= cfg_data;
          lcg_pkg::CFG_INCR:    incr          <= cfg_data;
          lcg_pkg::CFG_MODULUS: modulus       <= cfg_data;
          lcg_pkg::CFG_SEED:    current_value <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        lcg_pkg::ST_IDLE: begin
          if (in_xfer && s_axis_tdata[0]) begin
            state <= lcg_pkg::ST_MUL;
          end
        end
        lcg_pkg::ST_MUL: begin
          cnt   <= '0;
          state <= lcg_pkg::ST_FRAC;
        end
        lcg_pkg::ST_FRAC: begin
          if (cnt == lcg_pkg::CNT_W'(lcg_pkg::FRAC_STEPS - 1)) begin
            cnt   <= '0;
            state <= lcg_pkg::ST_MOD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        lcg_pkg::ST_MOD: begin
          if (cnt == lcg_pkg::CNT_W'(lcg_pkg::MOD_STEPS - 1)) begin
            cnt   <= '0;
            state <= lcg_pkg::ST_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        lcg_pkg::ST_OUT: begin
          if (out_load) begin
            current_value <= rem[30:0];
            state         <= lcg_pkg::ST_IDLE;
          end
        end
        default: state <= lcg_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      lcg_pkg::ST_MUL: begin
        prod <= 63'(mult * current_value);
        sat  <= ({1'b0, current_value} >= meff);
        rem  <= {1'b0, current_value};
        dvd  <= '0;
        quo  <= '0;
      end
      lcg_pkg::ST_FRAC: begin
        if (cnt == lcg_pkg::CNT_W'(lcg_pkg::FRAC_STEPS - 1)) begin
          frac <= sat ? lcg_pkg::FRAC_SAT : {quo[30:0], step_q};
          rem  <= '0;
          dvd  <= {1'b0, prod} + {32'd0, incr};
        end else begin
          rem <= step_rem;
          dvd <= {dvd[62:0], 1'b0};
          quo <= {quo[30:0], step_q};
        end
      end
      lcg_pkg::ST_MOD: begin
        rem <= step_rem;
        dvd <= {dvd[62:0], 1'b0};
      end
      lcg_pkg::ST_OUT: begin
        if (out_load) begin
          out_raw  <= current_value;
          out_frac <= frac;
        end
      end
      default: ;
    endcase
  end

  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    (state == lcg_pkg::ST_MOD) |-> (rem < meff))
    else $error("modulo remainder not below modulus");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == lcg_pkg::ST_OUT))
    else $error("result appeared outside the output step");

  a_frac_count: assert property (@(posedge clk) disable iff (rst)
    (state == lcg_pkg::ST_FRAC) |-> (cnt < lcg_pkg::CNT_W'(lcg_pkg::FRAC_STEPS)))
    else $error("fraction step count overrun");

  a_mul_to_frac: assert property (@(posedge clk) disable iff (rst)
    (state == lcg_pkg::ST_MUL) |=> (state == lcg_pkg::ST_FRAC) && (cnt == '0))
    else $error("divider not started after multiply");

endmodule

`default_nettype wire
